[hw/rtl/ljpf_pkg.sv]
package ljpf_pkg;

    // pair queue between front and back
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // clamp for intermediate q16.16 products
    localparam logic [47:0] LIMIT = 48'hFFFF_FFFF_FFFF;

    // pair class and result status codes
    localparam logic [1:0] ST_BEYOND  = 2'd0;
    localparam logic [1:0] ST_APPLIED = 2'd1;
    localparam logic [1:0] ST_COINC   = 2'd2;
    localparam logic [1:0] ST_LIMIT   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SIGMA  = 2'd0;
    localparam logic [1:0] REG_EPS    = 2'd1;
    localparam logic [1:0] REG_CUTOFF = 2'd2;

    typedef struct packed {
        logic [31:0] sigma;
        logic [31:0] eps;
        logic [31:0] cutoff;
    } t_cfg;

    // classified pair as it leaves the front
    typedef struct packed {
        logic [63:0]       r2;
        logic [2:0][31:0]  mag;
        logic [2:0]        neg;
        logic [1:0]        cls;
    } t_pair;

    typedef struct packed {
        logic              valid;
        logic [2:0][31:0]  fb;
        logic [1:0]        status;
    } t_result;

endpackage

[hw/rtl/ljpf_front.sv]
module ljpf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0][31:0]    i_pos_a,
    input  logic [2:0][31:0]    i_pos_b,
    input  logic [31:0]         i_cutoff,
    output logic                o_push,
    output ljpf_pkg::t_pair     o_pair
);
    import ljpf_pkg::*;

    logic [32:0]       w_d   [3];
    logic [32:0]       w_abs [3];
    logic              r_v1, r_v2, r_v3;
    logic [2:0][31:0]  r_mag1, r_mag2;
    logic [2:0]        r_neg1, r_neg2;
    logic [63:0]       r_sq2 [3];
    logic [63:0]       r_cut2;
    logic [65:0]       w_sum;
    t_pair             r_pair;

    // lane differences and magnitudes
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k]   = {i_pos_b[k][31], i_pos_b[k]} - {i_pos_a[k][31], i_pos_a[k]};
            w_abs[k] = w_d[k][32] ? (~w_d[k] + 33'd1) : w_d[k];
        end
    end

    // squared cutoff follows the register
    always_ff @(posedge i_clk) begin
        r_cut2 <= i_cutoff * i_cutoff;
    end

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage one: magnitudes, stage two: squares
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_mag1[k] <= w_abs[k][31:0];
            r_neg1[k] <= w_d[k][32];
            r_sq2[k]  <= r_mag1[k] * r_mag1[k];
        end
        r_mag2 <= r_mag1;
        r_neg2 <= r_neg1;
    end

    // stage three: sum and classify
    assign w_sum = {2'b0, r_sq2[0]} + {2'b0, r_sq2[1]} + {2'b0, r_sq2[2]};

    always_ff @(posedge i_clk) begin
        r_pair.r2  <= w_sum[63:0];
        r_pair.mag <= r_mag2;
        r_pair.neg <= r_neg2;
        if ((w_sum[65:64] != 2'b0) || (w_sum[63:0] >= r_cut2)) begin
            r_pair.cls <= ST_BEYOND;
        end else if (w_sum[63:0] == 64'd0) begin
            r_pair.cls <= ST_COINC;
        end else begin
            r_pair.cls <= ST_APPLIED;
        end
    end

    assign o_push = r_v3;
    assign o_pair = r_pair;

endmodule

[hw/rtl/ljpf_queue.sv]
module ljpf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ljpf_pkg::t_pair     i_pair,
    input  logic                i_pop,
    output logic                o_empty,
    output ljpf_pkg::t_pair     o_head
);
    import ljpf_pkg::*;

    t_pair               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QCNT_W-1:0]   r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_pair;
    end

    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != QCNT_W'(QDEPTH)))
        else $error("pair queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("pair queue read while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("fill count missed a beat");

endmodule

[hw/rtl/ljpf_back.sv]
module ljpf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ljpf_pkg::t_cfg      i_cfg,
    input  logic                i_empty,
    input  ljpf_pkg::t_pair     i_head,
    output logic                o_pop,
    output ljpf_pkg::t_result   o_res
);
    import ljpf_pkg::*;

    // sequencer phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_LOAD  = 3'd1;
    localparam logic [2:0] PH_RUN   = 3'd2;
    localparam logic [2:0] PH_STORE = 3'd3;
    localparam logic [2:0] PH_EMIT  = 3'd4;

    // operation steps
    localparam logic [3:0] STEP_SQRT = 4'd0;
    localparam logic [3:0] STEP_S    = 4'd1;
    localparam logic [3:0] STEP_S2   = 4'd2;
    localparam logic [3:0] STEP_S4   = 4'd3;
    localparam logic [3:0] STEP_S6   = 4'd4;
    localparam logic [3:0] STEP_S12  = 4'd5;
    localparam logic [3:0] STEP_W    = 4'd6;
    localparam logic [3:0] STEP_Q    = 4'd7;
    localparam logic [3:0] STEP_P0   = 4'd8;
    localparam logic [3:0] STEP_F0   = 4'd9;
    localparam logic [3:0] STEP_P1   = 4'd10;
    localparam logic [3:0] STEP_F1   = 4'd11;
    localparam logic [3:0] STEP_P2   = 4'd12;
    localparam logic [3:0] STEP_F2   = 4'd13;

    logic [2:0]        r_ph;
    logic [3:0]        r_step;
    logic [5:0]        r_cnt;
    logic              r_valid;
    logic [63:0]       r_r2;
    logic [2:0][31:0]  r_mag;
    logic [2:0]        r_dneg;
    logic [1:0]        r_cls;
    logic [31:0]       r_r;
    logic [35:0]       r_rem;
    logic [63:0]       r_opa, r_opb;
    logic [127:0]      r_acc;
    logic [47:0]       r_s, r_s2, r_s4, r_s6, r_w;
    logic [51:0]       r_hmag;
    logic              r_hneg;
    logic [63:0]       r_q, r_prod;
    logic              r_pov;
    logic              r_hit;
    logic [2:0][31:0]  r_fb;
    logic [1:0]        r_status;

    logic              w_is_sqrt, w_is_div;
    logic [3:0]        w_off;
    logic [1:0]        w_k;
    logic [32:0]       w_dsh;
    logic              w_dge;
    logic [35:0]       w_ssh, w_trial;
    logic              w_sge;
    logic [79:0]       w_pp;
    logic              w_movf;
    logic [47:0]       w_mq;
    logic [51:0]       w_a12, w_a6;
    logic [63:0]       w_fq;
    logic              w_fneg;
    logic [31:0]       w_fval;
    logic              w_fhit;

    // step decode
    assign w_is_sqrt = (r_step == STEP_SQRT);
    assign w_is_div  = (r_step == STEP_S) || (r_step == STEP_Q) || (r_step == STEP_F0)
                    || (r_step == STEP_F1) || (r_step == STEP_F2);
    assign w_off     = r_step - STEP_P0;
    assign w_k       = w_off[2:1];

    // restoring divider step, divisor is r
    assign w_dsh = {r_rem[31:0], r_opb[63]};
    assign w_dge = (w_dsh >= {1'b0, r_r});

    // square root step, two radicand bits a cycle
    assign w_ssh   = {r_rem[33:0], r_opb[63:62]};
    assign w_trial = {2'b0, r_r, 2'b01};
    assign w_sge   = (w_ssh >= w_trial);

    // multiplier step, sixteen bits of b a cycle
    assign w_pp   = r_opa * r_opb[63:48];
    assign w_movf = |r_acc[127:64];
    assign w_mq   = w_movf ? LIMIT : r_acc[63:16];

    // 12*s12 and 6*s6
    assign w_a12 = ({4'b0, w_mq} << 3) + ({4'b0, w_mq} << 2);
    assign w_a6  = ({4'b0, r_s6} << 2) + ({4'b0, r_s6} << 1);

    // component saturation
    assign w_fq   = r_pov ? 64'hFFFF_FFFF_FFFF_FFFF : r_opb;
    assign w_fneg = r_hneg ^ r_dneg[w_k];
    always_comb begin
        w_fhit = 1'b0;
        w_fval = w_fq[31:0];
        if (w_fneg) begin
            if (w_fq > 64'h8000_0000) begin
                w_fhit = 1'b1;
                w_fval = 32'h8000_0000;
            end else begin
                w_fval = 32'd0 - w_fq[31:0];
            end
        end else if (w_fq > 64'h7FFF_FFFF) begin
            w_fhit = 1'b1;
            w_fval = 32'h7FFF_FFFF;
        end
    end

    assign o_pop = (r_ph == PH_IDLE) && !i_empty;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= PH_IDLE;
            r_step  <= STEP_SQRT;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_ph)
                PH_IDLE: begin
                    if (!i_empty) begin
                        r_step <= STEP_SQRT;
                        r_ph   <= (i_head.cls == ST_APPLIED) ? PH_LOAD : PH_EMIT;
                    end
                end
                PH_LOAD: begin
                    r_ph  <= PH_RUN;
                    r_cnt <= w_is_sqrt ? 6'd31 : (w_is_div ? 6'd63 : 6'd3);
                end
                PH_RUN: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_ph <= PH_STORE;
                end
                PH_STORE: begin
                    if (r_step == STEP_F2) begin
                        r_ph <= PH_EMIT;
                    end else begin
                        r_step <= r_step + 1'b1;
                        r_ph   <= PH_LOAD;
                    end
                end
                PH_EMIT: begin
                    r_valid <= 1'b1;
                    r_ph    <= PH_IDLE;
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_ph)
            PH_IDLE: begin
                r_r2   <= i_head.r2;
                r_mag  <= i_head.mag;
                r_dneg <= i_head.neg;
                r_cls  <= i_head.cls;
                r_hit  <= 1'b0;
                r_fb   <= '0;
            end
            PH_LOAD: begin
                r_rem <= '0;
                r_acc <= '0;
                unique case (r_step)
                    STEP_SQRT: begin
                        r_opb <= r_r2;
                        r_r   <= '0;
                    end
                    STEP_S:   r_opb <= {16'b0, i_cfg.sigma, 16'b0};
                    STEP_S2: begin
                        r_opa <= {16'b0, r_s};
                        r_opb <= {16'b0, r_s};
                    end
                    STEP_S4: begin
                        r_opa <= {16'b0, r_s2};
                        r_opb <= {16'b0, r_s2};
                    end
                    STEP_S6: begin
                        r_opa <= {16'b0, r_s4};
                        r_opb <= {16'b0, r_s2};
                    end
                    STEP_S12: begin
                        r_opa <= {16'b0, r_s6};
                        r_opb <= {16'b0, r_s6};
                    end
                    STEP_W: begin
                        r_opa <= {32'b0, i_cfg.eps};
                        r_opb <= {12'b0, r_hmag};
                    end
                    STEP_Q:   r_opb <= {r_w, 16'b0};
                    STEP_P0, STEP_P1, STEP_P2: begin
                        r_opa <= r_q;
                        r_opb <= {32'b0, r_mag[w_k]};
                    end
                    default:  r_opb <= r_prod;
                endcase
            end
            PH_RUN: begin
                if (w_is_sqrt) begin
                    r_rem <= w_sge ? (w_ssh - w_trial) : w_ssh;
                    r_r   <= {r_r[30:0], w_sge};
                    r_opb <= {r_opb[61:0], 2'b0};
                end else if (w_is_div) begin
                    r_rem <= {4'b0, (w_dge ? (w_dsh[31:0] - r_r) : w_dsh[31:0])};
                    r_opb <= {r_opb[62:0], w_dge};
                end else begin
                    r_acc <= {r_acc[111:0], 16'b0} + {48'b0, w_pp};
                    r_opb <= {r_opb[47:0], 16'b0};
                end
            end
            PH_STORE: begin
                unique case (r_step)
                    STEP_SQRT: ;
                    STEP_S:   r_s <= r_opb[47:0];
                    STEP_S2: begin
                        r_s2  <= w_mq;
                        r_hit <= r_hit | w_movf;
                    end
                    STEP_S4: begin
                        r_s4  <= w_mq;
                        r_hit <= r_hit | w_movf;
                    end
                    STEP_S6: begin
                        r_s6  <= w_mq;
                        r_hit <= r_hit | w_movf;
                    end
                    STEP_S12: begin
                        r_hit  <= r_hit | w_movf;
                        r_hneg <= (w_a12 < w_a6);
                        r_hmag <= (w_a12 >= w_a6) ? (w_a12 - w_a6) : (w_a6 - w_a12);
                    end
                    STEP_W: begin
                        r_w   <= w_mq;
                        r_hit <= r_hit | w_movf;
                    end
                    STEP_Q:   r_q <= r_opb;
                    STEP_P0, STEP_P1, STEP_P2: begin
                        r_prod <= r_acc[63:0];
                        r_pov  <= w_movf;
                    end
                    default: begin
                        r_fb[w_k] <= w_fval;
                        r_hit     <= r_hit | w_fhit;
                    end
                endcase
            end
            PH_EMIT: begin
                r_status <= (r_cls == ST_APPLIED) ? (r_hit ? ST_LIMIT : ST_APPLIED) : r_cls;
            end
            default: ;
        endcase
    end

    assign o_res.valid  = r_valid;
    assign o_res.fb     = r_fb;
    assign o_res.status = r_status;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");
    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == ST_COINC)) |-> (r_fb == '0))
        else $error("coincident pair with nonzero force");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_RUN) |-> (r_step <= STEP_F2))
        else $error("sequencer step out of range");

endmodule

[hw/rtl/lennard_jones_pair_force_cutoff_top.sv]
// channel   | signals                                   | beat taken when
// ----------+-------------------------------------------+-------------------------
// pair in   | start, busy, i_pos_a_*, i_pos_b_*         | start high, busy low
// force out | o_done, o_force_b_*, o_pair_status        | every cycle o_done is high
// config    | i_cfg_we, i_cfg_idx, i_cfg_wdata          | i_cfg_we high
//
// the front takes a pair every cycle while busy is low and classifies it into an
// eight-entry queue; busy rises once eight pairs are outstanding.
// the back takes no new pair until it is done with the last. a pair inside the cutoff
// runs the shared one-bit-a-cycle divider (five divides), the two-bit-a-cycle square
// root and eight multiplies; a pair at or beyond it or coincident goes straight to its result.
// reset is synchronous, active low, and loads sigma 1.0, scale 1.0, cutoff 5.0.
// results cannot be held off: o_done marks each beat for exactly one cycle.
module lennard_jones_pair_force_cutoff_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_pos_a_x,
    input  logic signed [31:0]  i_pos_a_y,
    input  logic signed [31:0]  i_pos_a_z,
    input  logic signed [31:0]  i_pos_b_x,
    input  logic signed [31:0]  i_pos_b_y,
    input  logic signed [31:0]  i_pos_b_z,
    output logic                o_done,
    output logic signed [31:0]  o_force_b_x,
    output logic signed [31:0]  o_force_b_y,
    output logic signed [31:0]  o_force_b_z,
    output logic [1:0]          o_pair_status,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata
);
    import ljpf_pkg::*;

    t_cfg                r_cfg;
    logic [QCNT_W-1:0]   r_occ;
    logic                w_accept;
    logic [2:0][31:0]    w_pos_a, w_pos_b;
    logic                w_push, w_pop, w_empty;
    t_pair               w_pair, w_head;
    t_result             w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sigma  <= 32'd65536;
            r_cfg.eps    <= 32'd65536;
            r_cfg.cutoff <= 32'd327680;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SIGMA:  r_cfg.sigma  <= i_cfg_wdata;
                REG_EPS:    r_cfg.eps    <= i_cfg_wdata;
                REG_CUTOFF: r_cfg.cutoff <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pairs in the front pipe or queue
    assign busy     = (r_occ == QCNT_W'(QDEPTH));
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + QCNT_W'(w_accept) - QCNT_W'(w_pop);
        end
    end

    assign w_pos_a = {i_pos_a_z, i_pos_a_y, i_pos_a_x};
    assign w_pos_b = {i_pos_b_z, i_pos_b_y, i_pos_b_x};

    ljpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_pos_a  (w_pos_a),
        .i_pos_b  (w_pos_b),
        .i_cutoff (r_cfg.cutoff),
        .o_push   (w_push),
        .o_pair   (w_pair)
    );

    ljpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pair  (w_pair),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    ljpf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (w_res)
    );

    assign o_done        = w_res.valid;
    assign o_force_b_x   = w_res.fb[0];
    assign o_force_b_y   = w_res.fb[1];
    assign o_force_b_z   = w_res.fb[2];
    assign o_pair_status = w_res.status;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ljpf_pkg::*;

    localparam logic [63:0] CLAMP48 = 64'h0000_FFFF_FFFF_FFFF;
    // index past the last register
    localparam logic [1:0]  REG_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [31:0] i_pos_a_x, i_pos_a_y, i_pos_a_z;
    logic signed [31:0] i_pos_b_x, i_pos_b_y, i_pos_b_z;
    logic o_done;
    logic signed [31:0] o_force_b_x, o_force_b_y, o_force_b_z;
    logic [1:0] o_pair_status;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    typedef struct {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic [1:0]  status;
    } t_force;

    t_force force_q[$];
    logic [31:0] m_sigma, m_eps, m_cutoff;
    int errors;

    lennard_jones_pair_force_cutoff_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pos_a_x(i_pos_a_x), .i_pos_a_y(i_pos_a_y), .i_pos_a_z(i_pos_a_z),
        .i_pos_b_x(i_pos_b_x), .i_pos_b_y(i_pos_b_y), .i_pos_b_z(i_pos_b_z),
        .o_done(o_done), .o_force_b_x(o_force_b_x), .o_force_b_y(o_force_b_y),
        .o_force_b_z(o_force_b_z), .o_pair_status(o_pair_status),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout
    initial begin
        #200ms;
        $display("tb failed");
        $finish;
    end

    // truncating integer square root
    function automatic logic [63:0] sqrt_floor(input logic [63:0] n);
        logic [63:0] res, bitv, rem;
        res = 0;
        rem = n;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // q16.16 product clamped at the 48-bit limit
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b,
                                         inout logic hit);
        logic [127:0] p;
        p = a * b;
        if (a == 0 || b == 0) return 0;
        if (p[127:64] != 0 || (p[63:0] >> 16) > CLAMP48) begin
            hit = 1'b1;
            return CLAMP48;
        end
        return p[63:0] >> 16;
    endfunction

    // expected force on the second particle
    function automatic t_force pair_force(input logic [31:0] ax, ay, az, bx, by, bz);
        t_force t;
        logic signed [32:0] d[3];
        logic [63:0] mag[3];
        logic [65:0] r2;
        logic [63:0] r, s, s2, s4, s6, s12, a12, a6, hmag, w, q, f;
        logic [127:0] prod;
        logic [31:0] outv[3];
        logic hneg, hit, neg;
        d[0] = $signed({bx[31], bx}) - $signed({ax[31], ax});
        d[1] = $signed({by[31], by}) - $signed({ay[31], ay});
        d[2] = $signed({bz[31], bz}) - $signed({az[31], az});
        r2 = 0;
        hit = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
            r2 = r2 + 66'(mag[k] * mag[k]);
        end
        t.fx = 0; t.fy = 0; t.fz = 0;
        if ((r2[65:64] != 2'b0) || r2[63:0] >= 64'(m_cutoff) * 64'(m_cutoff)) begin
            t.status = ST_BEYOND;
            return t;
        end
        if (r2 == 0) begin
            t.status = ST_COINC;
            return t;
        end
        r = sqrt_floor(r2[63:0]);
        s = (64'(m_sigma) << 16) / r;
        s2 = qmul(s, s, hit);
        s4 = qmul(s2, s2, hit);
        s6 = qmul(s4, s2, hit);
        s12 = qmul(s6, s6, hit);
        a12 = 12 * s12;
        a6 = 6 * s6;
        hneg = a12 < a6;
        hmag = hneg ? a6 - a12 : a12 - a6;
        w = qmul(64'(m_eps), hmag, hit);
        q = (w << 16) / r;
        for (int k = 0; k < 3; k++) begin
            neg = hneg != (d[k] < 0);
            if (mag[k] == 0) begin
                outv[k] = 0;
            end else begin
                prod = q * mag[k];
                f = prod[127:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0] / r;
                if (neg) begin
                    if (f > 64'h8000_0000) begin
                        f = 64'h8000_0000;
                        hit = 1;
                    end
                    outv[k] = 32'(0 - f);
                end else begin
                    if (f > 64'h7FFF_FFFF) begin
                        f = 64'h7FFF_FFFF;
                        hit = 1;
                    end
                    outv[k] = f[31:0];
                end
            end
        end
        t.fx = outv[0]; t.fy = outv[1]; t.fz = outv[2];
        t.status = hit ? ST_LIMIT : ST_APPLIED;
        return t;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_force e;
        if (i_rst_n && o_done) begin
            if (force_q.size() == 0) begin
                $display("%0t unexpected beat: actual %h %h %h %0d", $time,
                         o_force_b_x, o_force_b_y, o_force_b_z, o_pair_status);
                errors++;
            end else begin
                e = force_q.pop_front();
                if (e.fx !== o_force_b_x || e.fy !== o_force_b_y ||
                    e.fz !== o_force_b_z || e.status !== o_pair_status) begin
                    $display("%0t mismatch: expected %h %h %h %0d actual %h %h %h %0d",
                             $time, e.fx, e.fy, e.fz, e.status, o_force_b_x,
                             o_force_b_y, o_force_b_z, o_pair_status);
                    errors++;
                end
            end
        end
    end

    int burst_left;

    // send one pair, with bursty gaps
    task automatic send_pair(input logic [31:0] ax, ay, az, bx, by, bz);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_pos_a_x <= ax; i_pos_a_y <= ay; i_pos_a_z <= az;
        i_pos_b_x <= bx; i_pos_b_y <= by; i_pos_b_z <= bz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        force_q.push_back(pair_force(ax, ay, az, bx, by, bz));
    endtask

    // stop sending, wait for every result, then settle
    task automatic drain();
        start <= 1'b0;
        while (force_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_SIGMA) m_sigma = val;
        else if (idx == REG_EPS) m_eps = val;
        else if (idx == REG_CUTOFF) m_cutoff = val;
    endtask

    task automatic set_cfg(input logic [31:0] sg, ep, co);
        drain();
        write_reg(REG_SIGMA, sg);
        write_reg(REG_EPS, ep);
        write_reg(REG_CUTOFF, co);
    endtask

    // random pair mostly near each other, some anywhere
    task automatic send_random(input logic [31:0] span);
        logic [31:0] ax, ay, az;
        ax = $urandom; ay = $urandom; az = $urandom;
        if ($urandom_range(0, 9) == 0)
            send_pair(ax, ay, az, $urandom, $urandom, $urandom);
        else
            send_pair(ax, ay, az,
                      ax + $urandom_range(0, 2 * span) - span,
                      ay + $urandom_range(0, 2 * span) - span,
                      az + $urandom_range(0, 2 * span) - span);
    endtask

    task automatic test_directed();
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(0, 0, 0, 32'h0001_0000, 0, 0);
        send_pair(0, 0, 0, 0, 32'hFFFF_0000, 0);
        send_pair(0, 0, 0, 0, 0, 32'h0001_2000);
        send_pair(0, 0, 0, 1, 0, 0);
        send_pair(0, 0, 0, 32'h0004_FFFF, 0, 0);
        send_pair(0, 0, 0, 32'h0005_0000, 0, 0);
        send_pair(32'h1234_0000, 0, 0, 32'h1235_8000, 32'h0000_8000, 32'hFFFF_8000);
        send_pair(0, 0, 0, 32'h0000_4000, 32'h0000_4000, 0);
        set_cfg(0, 65536, 327680);
        send_pair(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
        set_cfg(65536, 0, 327680);
        send_pair(0, 0, 0, 32'h0000_1000, 0, 0);
        send_pair(0, 0, 0, 32'h0001_0000, 0, 0);
        set_cfg(65536, 65536, 0);
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 1, 0, 0);
        set_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(0, 0, 0, 32'h0100_0000, 0, 0);
        drain();
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        send_pair(0, 0, 0, 32'h0100_0000, 0, 0);
    endtask

    task automatic test_random();
        logic [31:0] spans[4];
        spans = '{32'h0000_4000, 32'h0002_0000, 32'h0008_0000, 32'h0100_0000};
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_cfg(65536, 65536, 327680);
                1: set_cfg($urandom_range(32768, 196608), $urandom, $urandom_range(0, 1 << 20));
                2: set_cfg(1, 65536, 32'hFFFF_FFFF);
                3: set_cfg(32'hFFFF_FFFF, 1, 32'h0100_0000);
                default: set_cfg($urandom, $urandom, $urandom);
            endcase
            for (int n = 0; n < 195; n++) begin
                if (p == 3 || p >= 5)
                    send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                else
                    send_random(spans[$urandom_range(0, 3)]);
            end
        end
    endtask

    initial begin
        errors = 0;
        burst_left = 0;
        m_sigma = 65536; m_eps = 65536; m_cutoff = 327680;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_pos_a_x <= 0; i_pos_a_y <= 0; i_pos_a_z <= 0;
        i_pos_b_x <= 0; i_pos_b_y <= 0; i_pos_b_z <= 0;
        i_cfg_we <= 1'b0; i_cfg_idx <= REG_SIGMA; i_cfg_wdata <= 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        drain();
        repeat (500) @(posedge i_clk);
        if (errors == 0 && force_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
